### design/quaternion_alu_fixed_point_defines.svh
// Assertion macros for the quaternion ALU checker.
// No dependencies; included by the checker file only.
`ifndef QUATERNION_ALU_FIXED_POINT_DEFINES_SVH
`define QUATERNION_ALU_FIXED_POINT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QALU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("qalu: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define QALU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("qalu: next-cycle check failed");

`endif

### design/qalu_pkg.sv
// Shared types, opcodes and product routing tables for the quaternion ALU.
// No dependencies.
package qalu_pkg;

	localparam int CW            = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int PW            = 2 * CW;
	localparam int SW            = PW + 2;

	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_SUB   = 3'd1,
		OP_MUL   = 3'd2,
		OP_SCALE = 3'd3,
		OP_CONJ  = 3'd4,
		OP_CMPEQ = 3'd5
	} op_t;

	typedef logic signed [CW-1:0] comp_t;
	typedef logic signed [CW:0]   lin_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [SW-1:0] wide_t;
	typedef logic [1:0]           idx_t;

	localparam comp_t COMP_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam comp_t COMP_MIN = {1'b1, {(CW-1){1'b0}}};

	// Hamilton product terms, component order x, y, z, w; cross terms reversed.
	localparam idx_t MUL_A [4][4] = '{
		'{2'd0, 2'd3, 2'd1, 2'd2},
		'{2'd1, 2'd3, 2'd2, 2'd0},
		'{2'd2, 2'd3, 2'd0, 2'd1},
		'{2'd3, 2'd0, 2'd1, 2'd2}
	};
	localparam idx_t MUL_B [4][4] = '{
		'{2'd3, 2'd0, 2'd2, 2'd1},
		'{2'd3, 2'd1, 2'd0, 2'd2},
		'{2'd3, 2'd2, 2'd1, 2'd0},
		'{2'd3, 2'd0, 2'd1, 2'd2}
	};
	localparam logic MUL_NEG [4][4] = '{
		'{1'b0, 1'b0, 1'b1, 1'b0},
		'{1'b0, 1'b0, 1'b1, 1'b0},
		'{1'b0, 1'b0, 1'b1, 1'b0},
		'{1'b0, 1'b1, 1'b1, 1'b1}
	};

endpackage

### design/qalu_if.sv
// Request and response channel interfaces for the quaternion ALU.
// Depends on qalu_pkg.
interface qalu_req_if;
	logic                  valid;
	logic                  ready;
	logic [2:0]            opcode;
	qalu_pkg::comp_t       a_x;
	qalu_pkg::comp_t       a_y;
	qalu_pkg::comp_t       a_z;
	qalu_pkg::comp_t       a_w;
	qalu_pkg::comp_t       b_x;
	qalu_pkg::comp_t       b_y;
	qalu_pkg::comp_t       b_z;
	qalu_pkg::comp_t       b_w;
	qalu_pkg::comp_t       scale_factor;

	modport source (output valid, opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
		scale_factor, input ready);
	modport sink (input valid, opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
		scale_factor, output ready);
endinterface

interface qalu_rsp_if;
	logic            valid;
	logic            ready;
	qalu_pkg::comp_t r_x;
	qalu_pkg::comp_t r_y;
	qalu_pkg::comp_t r_z;
	qalu_pkg::comp_t r_w;
	logic            equal_flag;
	logic            overflow_flag;

	modport source (output valid, r_x, r_y, r_z, r_w, equal_flag, overflow_flag,
		input ready);
	modport sink (input valid, r_x, r_y, r_z, r_w, equal_flag, overflow_flag,
		output ready);
endinterface

### design/quaternion_alu_fixed_point.sv
// Quaternion ALU, signed fixed point, three register stages.
// A request passes through the stage 1, stage 2 and stage 3 registers before its response is offered.
// Throughput: one transaction per cycle; stalls collapse bubbles stage by stage.
// Stage 1 holds the 16 multiplier products, stage 2 the summed and shifted
// value, stage 3 the saturated result. arst_n clears only the stage valid bits.
// Depends on qalu_pkg and qalu_if.
module quaternion_alu_fixed_point #(
	parameter int FRAC_BITS = qalu_pkg::FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	qalu_req_if.sink   req,
	qalu_rsp_if.source rsp
);

	logic en_s1, en_s2, en_s3;
	logic v_s1, v_s2, v_s3;

	assign en_s3     = !v_s3 || rsp.ready;
	assign en_s2     = !v_s2 || en_s3;
	assign en_s1     = !v_s1 || en_s2;
	assign req.ready = en_s1;

	// stage 0: operand routing
	qalu_pkg::op_t   op_in;
	qalu_pkg::comp_t a [4];
	qalu_pkg::comp_t b [4];
	qalu_pkg::comp_t ma [4][4];
	qalu_pkg::comp_t mb [4][4];
	qalu_pkg::lin_t  lin_c [4];
	logic            eq_c;

	assign op_in = qalu_pkg::op_t'(req.opcode);
	assign a[0] = req.a_x;
	assign a[1] = req.a_y;
	assign a[2] = req.a_z;
	assign a[3] = req.a_w;
	assign b[0] = req.b_x;
	assign b[1] = req.b_y;
	assign b[2] = req.b_z;
	assign b[3] = req.b_w;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				if (op_in == qalu_pkg::OP_SCALE) begin
					ma[i][j] = (j == 0) ? req.scale_factor : '0;
					mb[i][j] = (j == 0) ? a[i] : '0;
				end else begin
					ma[i][j] = a[qalu_pkg::MUL_A[i][j]];
					mb[i][j] = b[qalu_pkg::MUL_B[i][j]];
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			case (op_in)
				qalu_pkg::OP_ADD: lin_c[i] = {a[i][qalu_pkg::CW-1], a[i]} +
					{b[i][qalu_pkg::CW-1], b[i]};
				qalu_pkg::OP_SUB: lin_c[i] = {a[i][qalu_pkg::CW-1], a[i]} -
					{b[i][qalu_pkg::CW-1], b[i]};
				qalu_pkg::OP_CONJ: lin_c[i] = (i == 3) ? {a[i][qalu_pkg::CW-1], a[i]} :
					'0 - {a[i][qalu_pkg::CW-1], a[i]};
				default: lin_c[i] = '0;
			endcase
		end
		eq_c = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]) && (a[3] == b[3]);
	end

	// stage 1: products
	qalu_pkg::op_t   op_s1;
	qalu_pkg::prod_t prod_s1 [4][4];
	qalu_pkg::lin_t  lin_s1 [4];
	logic            eq_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			op_s1 <= op_in;
			eq_s1 <= eq_c;
			for (int i = 0; i < 4; i++) begin
				lin_s1[i] <= lin_c[i];
				for (int j = 0; j < 4; j++) begin
					prod_s1[i][j] <= ma[i][j] * mb[i][j];
				end
			end
		end
	end

	// stage 2: sum of terms, scaling shift, result select
	qalu_pkg::wide_t sum_c [4];
	qalu_pkg::wide_t val_c [4];
	qalu_pkg::op_t   op_s2;
	qalu_pkg::wide_t val_s2 [4];
	logic            eq_s2;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sum_c[i] = '0;
			for (int j = 0; j < 4; j++) begin
				if (qalu_pkg::MUL_NEG[i][j]) begin
					sum_c[i] = sum_c[i] - qalu_pkg::wide_t'(prod_s1[i][j]);
				end else begin
					sum_c[i] = sum_c[i] + qalu_pkg::wide_t'(prod_s1[i][j]);
				end
			end
			case (op_s1)
				qalu_pkg::OP_MUL:   val_c[i] = sum_c[i] >>> FRAC_BITS;
				qalu_pkg::OP_SCALE: val_c[i] = qalu_pkg::wide_t'(prod_s1[i][0]) >>> FRAC_BITS;
				qalu_pkg::OP_ADD,
				qalu_pkg::OP_SUB,
				qalu_pkg::OP_CONJ:  val_c[i] = qalu_pkg::wide_t'(lin_s1[i]);
				default:            val_c[i] = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			op_s2 <= op_s1;
			eq_s2 <= eq_s1;
			for (int i = 0; i < 4; i++) begin
				val_s2[i] <= val_c[i];
			end
		end
	end

	// stage 3: saturation and flags
	qalu_pkg::comp_t res_c [4];
	logic            ovf_c;
	logic            eqf_c;
	logic            fit;
	logic            live;
	qalu_pkg::comp_t res_s3 [4];
	logic            ovf_s3;
	logic            eqf_s3;

	always_comb begin
		live  = (op_s2 == qalu_pkg::OP_ADD) || (op_s2 == qalu_pkg::OP_SUB) ||
			(op_s2 == qalu_pkg::OP_MUL) || (op_s2 == qalu_pkg::OP_SCALE) ||
			(op_s2 == qalu_pkg::OP_CONJ);
		eqf_c = (op_s2 == qalu_pkg::OP_CMPEQ) && eq_s2;
		ovf_c = 1'b0;
		fit   = 1'b1;
		for (int i = 0; i < 4; i++) begin
			fit = (&val_s2[i][qalu_pkg::SW-1:qalu_pkg::CW-1]) ||
				!(|val_s2[i][qalu_pkg::SW-1:qalu_pkg::CW-1]);
			if (!live) begin
				res_c[i] = '0;
			end else if (fit) begin
				res_c[i] = val_s2[i][qalu_pkg::CW-1:0];
			end else begin
				res_c[i] = val_s2[i][qalu_pkg::SW-1] ? qalu_pkg::COMP_MIN : qalu_pkg::COMP_MAX;
				ovf_c    = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			ovf_s3 <= ovf_c;
			eqf_s3 <= eqf_c;
			for (int i = 0; i < 4; i++) begin
				res_s3[i] <= res_c[i];
			end
		end
	end

	assign rsp.valid         = v_s3;
	assign rsp.r_x           = res_s3[0];
	assign rsp.r_y           = res_s3[1];
	assign rsp.r_z           = res_s3[2];
	assign rsp.r_w           = res_s3[3];
	assign rsp.equal_flag    = eqf_s3;
	assign rsp.overflow_flag = ovf_s3;

endmodule

### design/qalu_checker.sv
// Port-level checker for the quaternion ALU, bound to the top level.
// Depends on qalu_pkg and quaternion_alu_fixed_point_defines.svh.
`include "quaternion_alu_fixed_point_defines.svh"

module qalu_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            req_ready,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input qalu_pkg::comp_t r_x,
	input qalu_pkg::comp_t r_y,
	input qalu_pkg::comp_t r_z,
	input qalu_pkg::comp_t r_w,
	input logic            equal_flag,
	input logic            overflow_flag
);

	`QALU_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(r_x) && $stable(r_w) && $stable(overflow_flag))

	`QALU_ASSERT_IMP(a_stall_source, clk, arst_n, !req_ready, rsp_valid && !rsp_ready)

	`QALU_ASSERT_IMP(a_cmp_clean, clk, arst_n, rsp_valid && equal_flag, !overflow_flag && r_x == '0 && r_y == '0 && r_z == '0 && r_w == '0)

	`QALU_ASSERT_IMP(a_ovf_clamped, clk, arst_n, rsp_valid && overflow_flag, r_x == qalu_pkg::COMP_MAX || r_x == qalu_pkg::COMP_MIN || r_y == qalu_pkg::COMP_MAX || r_y == qalu_pkg::COMP_MIN || r_z == qalu_pkg::COMP_MAX || r_z == qalu_pkg::COMP_MIN || r_w == qalu_pkg::COMP_MAX || r_w == qalu_pkg::COMP_MIN)

endmodule

bind quaternion_alu_fixed_point qalu_checker u_qalu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.r_x           (rsp.r_x),
	.r_y           (rsp.r_y),
	.r_z           (rsp.r_z),
	.r_w           (rsp.r_w),
	.equal_flag    (rsp.equal_flag),
	.overflow_flag (rsp.overflow_flag)
);

### tb/quaternion_alu_fixed_point_tb.sv
// Testbench for quaternion_alu_fixed_point: a directed table, then random transactions.
// Each response is checked against its table value or a local Q16.16 quaternion predictor.
// Depends on qalu_pkg, qalu_if and the quaternion_alu_fixed_point RTL.
`timescale 1ns / 1ps

module quaternion_alu_fixed_point_tb;
	import qalu_pkg::*;

	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;
	localparam logic [2:0] OP_LIST [8] = '{OP_ADD, OP_SUB, OP_MUL, OP_SCALE, OP_CONJ,
		OP_CMPEQ, OP_RSVD6, OP_RSVD7};
	localparam comp_t Q_ONE = 32'sh0001_0000;
	localparam int    N_RANDOM = 900;
	localparam int    HOLD_AT = 300;
	localparam int    HOLD_CYCLES = 200;

	typedef struct packed {
		logic [2:0]  opcode;
		comp_t [3:0] a;
		comp_t [3:0] b;
		comp_t       k;
	} quat_req_t;

	typedef struct packed {
		comp_t [3:0] r;
		logic        eq;
		logic        ovf;
	} quat_rsp_t;

	typedef struct packed {
		quat_req_t req;
		logic      typed;
		quat_rsp_t rsp;
	} stim_row_t;

	logic clk;
	logic arst_n;

	qalu_req_if req_ch();
	qalu_rsp_if rsp_ch();

	quaternion_alu_fixed_point dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	stim_row_t stim_tab[$];
	quat_rsp_t pending_results[$];
	int        n_results = 0;
	int        n_mismatch = 0;
	logic      rsp_hold;

	// Exact products and sums, arithmetic shift, then clamp to the component range.
	function automatic quat_rsp_t quat_alu_result(quat_req_t t);
		logic signed [127:0] a [4];
		logic signed [127:0] b [4];
		logic signed [127:0] v [4];
		logic signed [127:0] k;
		logic signed [127:0] hi;
		logic signed [127:0] lo;
		logic                arith;
		int                  i;
		quat_rsp_t           o;
		o = '0;
		arith = 1'b1;
		hi = COMP_MAX;
		lo = COMP_MIN;
		k = $signed(t.k);
		for (i = 0; i < 4; i++) begin
			a[i] = $signed(t.a[i]);
			b[i] = $signed(t.b[i]);
			v[i] = '0;
		end
		case (t.opcode)
			OP_ADD: begin
				for (i = 0; i < 4; i++) v[i] = a[i] + b[i];
			end
			OP_SUB: begin
				for (i = 0; i < 4; i++) v[i] = a[i] - b[i];
			end
			OP_MUL: begin
				v[0] = (a[0] * b[3] + a[3] * b[0] - a[1] * b[2] + a[2] * b[1]) >>> FRAC_BITS_DEF;
				v[1] = (a[1] * b[3] + a[3] * b[1] - a[2] * b[0] + a[0] * b[2]) >>> FRAC_BITS_DEF;
				v[2] = (a[2] * b[3] + a[3] * b[2] - a[0] * b[1] + a[1] * b[0]) >>> FRAC_BITS_DEF;
				v[3] = (a[3] * b[3] - a[0] * b[0] - a[1] * b[1] - a[2] * b[2]) >>> FRAC_BITS_DEF;
			end
			OP_SCALE: begin
				for (i = 0; i < 4; i++) v[i] = (k * a[i]) >>> FRAC_BITS_DEF;
			end
			OP_CONJ: begin
				for (i = 0; i < 3; i++) v[i] = -a[i];
				v[3] = a[3];
			end
			OP_CMPEQ: begin
				o.eq = (t.a == t.b);
				arith = 1'b0;
			end
			default: begin
				arith = 1'b0;
			end
		endcase
		if (arith) begin
			for (i = 0; i < 4; i++) begin
				if (v[i] > hi) begin
					o.r[i] = COMP_MAX;
					o.ovf = 1'b1;
				end else if (v[i] < lo) begin
					o.r[i] = COMP_MIN;
					o.ovf = 1'b1;
				end else begin
					o.r[i] = v[i][CW-1:0];
				end
			end
		end
		return o;
	endfunction

	function automatic quat_req_t mk_req(logic [2:0] op, comp_t ax, comp_t ay, comp_t az,
			comp_t aw, comp_t bx, comp_t by, comp_t bz, comp_t bw, comp_t k);
		quat_req_t t;
		t.opcode = op;
		t.a = {aw, az, ay, ax};
		t.b = {bw, bz, by, bx};
		t.k = k;
		return t;
	endfunction

	function automatic quat_rsp_t mk_rsp(comp_t rx, comp_t ry, comp_t rz, comp_t rw,
			logic eq, logic ovf);
		quat_rsp_t o;
		o.r = {rw, rz, ry, rx};
		o.eq = eq;
		o.ovf = ovf;
		return o;
	endfunction

	task automatic add_row(quat_req_t t, logic typed, quat_rsp_t want);
		stim_row_t row;
		row.req = t;
		row.typed = typed;
		row.rsp = want;
		stim_tab.push_back(row);
	endtask

	function automatic comp_t small_comp();
		return comp_t'($urandom_range(0, 32'h000F_FFFF)) - comp_t'(32'h0008_0000);
	endfunction

	function automatic comp_t rand_comp();
		case ($urandom_range(0, 9))
			0: return COMP_MAX;
			1: return COMP_MIN;
			2: return ($urandom_range(0, 1)) ? Q_ONE : -Q_ONE;
			3, 4, 5: return comp_t'($urandom);
			default: return small_comp();
		endcase
	endfunction

	function automatic quat_req_t rand_req();
		quat_req_t t;
		int        idx;
		int        i;
		logic      tame;
		idx = $urandom_range(0, 31);
		t.opcode = (idx < 30) ? OP_LIST[idx % 6] : OP_LIST[idx - 24];
		tame = ($urandom_range(0, 1) == 0);
		for (i = 0; i < 4; i++) begin
			t.a[i] = tame ? small_comp() : rand_comp();
			t.b[i] = tame ? small_comp() : rand_comp();
		end
		t.k = tame ? small_comp() : rand_comp();
		if (t.opcode == OP_CMPEQ && $urandom_range(0, 3) != 0) begin
			t.b = t.a;
			if ($urandom_range(0, 1))
				t.b[$urandom_range(0, 3)][$urandom_range(0, CW - 1)] ^= 1'b1;
		end
		return t;
	endfunction

	function automatic int gap_len(int zero_odds);
		if ($urandom_range(0, 99) < zero_odds)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	task automatic send_quat(quat_req_t t, logic typed, quat_rsp_t want);
		req_ch.valid <= 1'b1;
		req_ch.opcode <= t.opcode;
		req_ch.a_x <= t.a[0];
		req_ch.a_y <= t.a[1];
		req_ch.a_z <= t.a[2];
		req_ch.a_w <= t.a[3];
		req_ch.b_x <= t.b[0];
		req_ch.b_y <= t.b[1];
		req_ch.b_z <= t.b[2];
		req_ch.b_w <= t.b[3];
		req_ch.scale_factor <= t.k;
		do @(posedge clk); while (!req_ch.ready);
		pending_results.push_back(typed ? want : quat_alu_result(t));
		@(negedge clk);
	endtask

	// Sender pause; runs of back-to-back transactions, and none while the sink holds off.
	task automatic req_pause(inout int burst);
		int g;
		if (burst > 0) begin
			burst--;
			g = 0;
		end else if (rsp_hold) begin
			g = 0;
		end else begin
			if ($urandom_range(0, 29) == 0)
				burst = $urandom_range(20, 60);
			g = gap_len(50);
		end
		if (g > 0) begin
			req_ch.valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin : req_side
		int burst;
		burst = 0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.opcode = '0;
		req_ch.a_x = '0;
		req_ch.a_y = '0;
		req_ch.a_z = '0;
		req_ch.a_w = '0;
		req_ch.b_x = '0;
		req_ch.b_y = '0;
		req_ch.b_z = '0;
		req_ch.b_w = '0;
		req_ch.scale_factor = '0;

		add_row(mk_req(OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, mk_rsp(0, 0, 0, 0, 0, 0));
		add_row(mk_req(OP_ADD, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX,
			COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, 0), 1,
			mk_rsp(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, 0, 1));
		add_row(mk_req(OP_ADD, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN,
			COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MAX), 1,
			mk_rsp(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, 0, 1));
		add_row(mk_req(OP_ADD, COMP_MAX, COMP_MIN, -1, Q_ONE, 1, COMP_MAX, 1, Q_ONE, 0), 1,
			mk_rsp(COMP_MAX, -1, 0, 32'sh0002_0000, 0, 1));
		add_row(mk_req(OP_SUB, COMP_MIN, COMP_MAX, 0, 5, 1, -1, COMP_MIN, 3, 0), 1,
			mk_rsp(COMP_MIN, COMP_MAX, COMP_MAX, 2, 0, 1));
		add_row(mk_req(OP_SUB, 7, -7, COMP_MAX, COMP_MIN, 7, -7, COMP_MAX, COMP_MIN, 0), 1,
			mk_rsp(0, 0, 0, 0, 0, 0));
		add_row(mk_req(OP_MUL, Q_ONE, 2 * Q_ONE, -3 * Q_ONE, 4 * Q_ONE, 0, 0, 0, Q_ONE, 0),
			0, '0);
		add_row(mk_req(OP_MUL, Q_ONE, 0, 0, 0, 0, Q_ONE, 0, 0, 0), 0, '0);
		add_row(mk_req(OP_MUL, 0, Q_ONE, 0, 0, Q_ONE, 0, 0, 0, 0), 0, '0);
		add_row(mk_req(OP_MUL, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN,
			COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, 0), 0, '0);
		add_row(mk_req(OP_MUL, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX,
			COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, 0), 0, '0);
		add_row(mk_req(OP_MUL, 0, 0, 0, -1, 0, 0, 0, 1, 0), 0, '0);
		add_row(mk_req(OP_MUL, 32'sh1234_5678, -32'sh0765_4321, 32'sh0000_ABCD, -32'sh0001_8000,
			32'sh0003_0000, 32'sh7654_3210, -32'sh0000_0101, 32'sh0002_4000, 0), 0, '0);
		add_row(mk_req(OP_SCALE, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, 0, 0, 0, 0, COMP_MIN),
			1, mk_rsp(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, 0, 1));
		add_row(mk_req(OP_SCALE, COMP_MAX, COMP_MIN, -1, Q_ONE, 3, 3, 3, 3, Q_ONE), 1,
			mk_rsp(COMP_MAX, COMP_MIN, -1, Q_ONE, 0, 0));
		add_row(mk_req(OP_SCALE, COMP_MAX, COMP_MIN, 5, -5, 0, 0, 0, 0, 0), 1,
			mk_rsp(0, 0, 0, 0, 0, 0));
		add_row(mk_req(OP_SCALE, 1, -1, COMP_MAX, COMP_MIN, 0, 0, 0, 0, -1), 0, '0);
		add_row(mk_req(OP_CONJ, COMP_MIN, COMP_MAX, 0, COMP_MIN, 9, 9, 9, 9, 9), 1,
			mk_rsp(COMP_MAX, COMP_MIN + 1, 0, COMP_MIN, 0, 1));
		add_row(mk_req(OP_CONJ, Q_ONE, -Q_ONE, 5, 9, 0, 0, 0, 0, 0), 0, '0);
		add_row(mk_req(OP_CMPEQ, 1, 2, 3, 4, 1, 2, 3, 4, 0), 1, mk_rsp(0, 0, 0, 0, 1, 0));
		add_row(mk_req(OP_CMPEQ, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN,
			COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, 0), 1, mk_rsp(0, 0, 0, 0, 1, 0));
		add_row(mk_req(OP_CMPEQ, 1, 2, 3, 4, 1, 2, 3, 5, 0), 1, mk_rsp(0, 0, 0, 0, 0, 0));
		add_row(mk_req(OP_CMPEQ, COMP_MAX, 0, 0, 0, -1, 0, 0, 0, 0), 1,
			mk_rsp(0, 0, 0, 0, 0, 0));
		add_row(mk_req(OP_RSVD6, COMP_MAX, COMP_MIN, 7, 7, COMP_MAX, 1, 7, 7, Q_ONE), 1,
			mk_rsp(0, 0, 0, 0, 0, 0));
		add_row(mk_req(OP_RSVD7, 1, 2, 3, 4, 1, 2, 3, 4, COMP_MIN), 1,
			mk_rsp(0, 0, 0, 0, 0, 0));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (stim_tab[n]) begin
			req_pause(burst);
			send_quat(stim_tab[n].req, stim_tab[n].typed, stim_tab[n].rsp);
		end
		repeat (N_RANDOM) begin
			req_pause(burst);
			send_quat(rand_req(), 1'b0, '0);
		end
		req_ch.valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (n_mismatch == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin : rsp_side
		logic held;
		held = 1'b0;
		rsp_hold = 1'b0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!held && n_results >= HOLD_AT) begin
				// long hold-off so the pipeline fills and backs up onto the request side
				held = 1'b1;
				rsp_hold = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				rsp_hold = 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap_len(0)) @(negedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin : rsp_check
		quat_rsp_t got;
		quat_rsp_t want;
		logic      bad;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = mk_rsp(rsp_ch.r_x, rsp_ch.r_y, rsp_ch.r_z, rsp_ch.r_w,
				rsp_ch.equal_flag, rsp_ch.overflow_flag);
			n_results++;
			if (pending_results.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("%0t: unexpected transaction r=%h %h %h %h eq=%b ovf=%b", $time,
						got.r[0], got.r[1], got.r[2], got.r[3], got.eq, got.ovf);
			end else begin
				want = pending_results.pop_front();
				bad = 1'b0;
				for (int i = 0; i < 4; i++)
					if (got.r[i] !== want.r[i])
						bad = 1'b1;
				if (got.eq !== want.eq)
					bad = 1'b1;
				if (got.ovf !== want.ovf)
					bad = 1'b1;
				if (bad) begin
					n_mismatch++;
					if (n_mismatch <= 10) begin
						$display("%0t: mismatch exp r=%h %h %h %h eq=%b ovf=%b", $time,
							want.r[0], want.r[1], want.r[2], want.r[3], want.eq, want.ovf);
						$display("%0t: mismatch got r=%h %h %h %h eq=%b ovf=%b", $time,
							got.r[0], got.r[1], got.r[2], got.r[3], got.eq, got.ovf);
					end
				end
			end
		end
	end

endmodule

### sim.f
+incdir+design
design/qalu_pkg.sv
design/qalu_if.sv
design/quaternion_alu_fixed_point.sv
design/qalu_checker.sv
tb/quaternion_alu_fixed_point_tb.sv
